/* hdl/saf_pkg.sv */
// ----------------------------------------------------------------------------
// saf_pkg
// Shared types, constants and arithmetic helpers of the selectable audio filter.
// ----------------------------------------------------------------------------
package saf_pkg;

    // filter modes
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_LOW   = 2'd1;
    localparam logic [1:0] MODE_HIGH  = 2'd2;
    localparam logic [1:0] MODE_MATCH = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_GAIN  = 2'd1;
    localparam logic [1:0] CFG_LEAK  = 2'd2;

    // reset values of the configuration registers
    localparam logic [1:0]  MODE_RST = MODE_MATCH;
    localparam logic [16:0] GAIN_RST = 17'd32768;
    localparam logic [16:0] LEAK_RST = 17'd66;

    // unity gain and matched-filter scale (8 * 32767)
    localparam logic [16:0] UNITY      = 17'd65536;
    localparam logic [17:0] UNITY2     = 18'd131072;
    localparam int          MATCH_DIV  = 262136;
    localparam int          QUOT_BITS  = 15;
    localparam longint      MATCH_SAT  = 64'd32768 * 64'd262136;

    // one classified input beat
    typedef struct packed {
        logic               is_coef;
        logic               start;
        logic signed [15:0] value;
        logic [6:0]         idx;
    } item_t;

    // configuration register set
    typedef struct packed {
        logic [1:0]  mode;
        logic [16:0] gain;
        logic [16:0] leak;
    } cfg_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_HIST,
        BK_MAC,
        BK_DIV,
        BK_FIX,
        BK_OUT
    } back_state_t;

    // clip to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767)
            r = 16'sh7fff;
        else if (v < -40'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // divide by a power of two, rounding toward zero
    function automatic logic signed [39:0] div_trunc(input logic signed [39:0] v,
                                                     input int sh);
        logic signed [39:0] bias;
        bias = (40'sd1 <<< sh) - 40'sd1;
        if (v < 40'sd0)
            return (v + bias) >>> sh;
        else
            return v >>> sh;
    endfunction

endpackage

/* hdl/saf_ram.sv */
// ----------------------------------------------------------------------------
// saf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module saf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/saf_front.sv */
// ----------------------------------------------------------------------------
// saf_front
// Accepts input beats, sorts them into samples and template writes, and
// queues them in a two-entry buffer for the back end.
// ----------------------------------------------------------------------------
module saf_front
    import saf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    output logic        q_valid,
    input  logic        q_pop,
    output item_t       q_item
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      in_item;
    logic       push;

    // classify the beat
    always_comb
    begin
        in_item.is_coef = s_axis_tuser[0];
        in_item.start   = s_axis_tuser[1];
        in_item.idx     = s_axis_tdata[22:16];
        in_item.value   = s_axis_tuser[0] ? s_axis_tdata[38:23] : s_axis_tdata[15:0];
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (cnt_reg != 2'd0);
    assign q_item        = slot_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hdl/saf_back.sv */
// ----------------------------------------------------------------------------
// saf_back
// Executes queued items: template writes, the low/high-pass updates on a
// shared multiplier, the decimated correlation one tap per cycle and a
// shift-based divide by the match scale, then presents the result in an
// output register.
// ----------------------------------------------------------------------------
module saf_back
    import saf_pkg::*;
#(
    parameter int TAPS  = 80,
    parameter int DECIM = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    output logic        q_pop,
    input  item_t       q_item,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata
);

    localparam int AW    = $clog2(TAPS);
    localparam int CW    = $clog2(TAPS + 1);
    localparam int PW    = $clog2(DECIM + 1);
    localparam int ACC_W = 32 + $clog2(TAPS);
    // match scale is 2^18 - 2^3
    localparam int DIV_SH  = 18;
    localparam int DIV_LSH = 3;

    back_state_t state_reg, state_next;

    item_t              item_reg;
    logic [2:0]         step_reg;
    logic signed [35:0] mul_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0] lp_reg, hp_reg, ta_reg;
    logic signed [15:0] prior_in_reg, prior_out_reg, held_reg;
    logic [PW-1:0]      phase_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      wp_reg, j_reg, rp_reg;
    logic               issue_done_reg, v1_reg, v2_reg, tv1_reg;
    logic [TAPS-1:0]    tvalid_reg;
    logic [ACC_W-1:0]   rem_reg;
    logic [QUOT_BITS-1:0] q_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic signed [15:0] out_data_reg;

    // control decode
    logic               coef_we, hist_we, out_load, mac_busy;
    logic [16:0]        g_eff, b_eff;
    logic signed [18:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [35:0] prod;
    logic signed [15:0] t_rdata, h_rdata, result, avg;
    logic signed [16:0] pair_sum;
    logic [PW-1:0]      phase_eff;
    logic [CW-1:0]      count_eff;
    logic [AW-1:0]      wp_inc, rp_dec;
    logic               warm;
    logic signed [ACC_W-1:0] acc_abs_s;
    logic [ACC_W-1:0]   acc_mag;
    logic [ACC_W-1:0]   est_sum, fix_rem;
    logic               fix_up;
    logic [15:0]        fix_q;

    assign g_eff = (cfg.gain > UNITY) ? UNITY : cfg.gain;
    assign b_eff = (cfg.leak > UNITY) ? UNITY : cfg.leak;

    // restart handling for the decimation group
    assign phase_eff = item_reg.start ? '0 : phase_reg;
    assign count_eff = item_reg.start ? '0 : count_reg;
    assign warm      = (count_eff == CW'(TAPS));
    assign wp_inc    = (wp_reg == AW'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_dec    = (rp_reg == '0) ? AW'(TAPS - 1) : rp_reg - 1'b1;

    // two-sample average, toward zero
    assign pair_sum = 17'(item_reg.value) + 17'(prior_in_reg);
    always_comb
    begin
        if (item_reg.start)
            avg = item_reg.value;
        else
            avg = 16'((pair_sum + 17'(pair_sum < 0)) >>> 1);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == BK_MAC)
        begin
            mul_a = 19'(tv1_reg ? t_rdata : 16'sd0);
            mul_b = 17'(h_rdata);
        end
        else
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = signed'({2'b00, g_eff});
                    mul_b = 17'(item_reg.value);
                end
                3'd1:
                begin
                    mul_a = signed'({2'b00, UNITY - g_eff});
                    mul_b = 17'(prior_out_reg);
                end
                3'd2:
                begin
                    mul_a = signed'({1'b0, UNITY2 - {1'b0, b_eff}});
                    mul_b = 17'(item_reg.value) - 17'(prior_in_reg);
                end
                3'd3:
                begin
                    mul_a = signed'({2'b00, UNITY - b_eff});
                    mul_b = 17'(prior_out_reg);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end
    assign prod = mul_a * mul_b;

    // output select by mode
    always_comb
    begin
        case (cfg.mode)
            MODE_PASS: result = item_reg.value;
            MODE_LOW:  result = lp_reg;
            MODE_HIGH: result = hp_reg;
            default:   result = held_reg;
        endcase
    end

    assign acc_abs_s = (acc_reg < 0) ? -acc_reg : acc_reg;
    assign acc_mag   = unsigned'(acc_abs_s);
    assign mac_busy  = !issue_done_reg || v1_reg || v2_reg;

    // quotient estimate m * (1 + 2^-15) / 2^18, low by at most one
    assign est_sum = rem_reg + (rem_reg >> 15);
    // remainder of the estimate and the single correction step
    assign fix_rem = rem_reg - (ACC_W'(q_reg) << DIV_SH) + (ACC_W'(q_reg) << DIV_LSH);
    assign fix_up  = (fix_rem >= ACC_W'(MATCH_DIV));
    assign fix_q   = {1'b0, q_reg} + 16'(fix_up);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (q_valid && !q_item.is_coef)
                    state_next = BK_MUL;
            BK_MUL:
                if (step_reg == 3'd4)
                    state_next = (phase_eff == '0) ? BK_HIST : BK_OUT;
            BK_HIST:
                state_next = warm ? BK_MAC : BK_OUT;
            BK_MAC:
                if (!mac_busy)
                    state_next = (acc_mag >= ACC_W'(MATCH_SAT)) ? BK_OUT : BK_DIV;
            BK_DIV:
                state_next = BK_FIX;
            BK_FIX:
                state_next = BK_OUT;
            BK_OUT:
                if (out_load)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop    = (state_reg == BK_IDLE) && q_valid;
        coef_we  = q_pop && q_item.is_coef && (32'(q_item.idx) < TAPS);
        hist_we  = (state_reg == BK_HIST);
        out_load = (state_reg == BK_OUT) && (!out_valid_reg || m_axis_tready);
    end

    // template and decimated history memories
    saf_ram #(.WIDTH(16), .DEPTH(TAPS)) u_tmpl (
        .clk   (clk),
        .we    (coef_we),
        .waddr (AW'(q_item.idx)),
        .wdata (q_item.value),
        .raddr (j_reg),
        .rdata (t_rdata)
    );

    saf_ram #(.WIDTH(16), .DEPTH(TAPS)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_inc),
        .wdata (avg),
        .raddr (rp_reg),
        .rdata (h_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            step_reg       <= '0;
            prior_in_reg   <= '0;
            prior_out_reg  <= '0;
            held_reg       <= '0;
            phase_reg      <= '0;
            count_reg      <= '0;
            wp_reg         <= '0;
            tvalid_reg     <= '0;
            issue_done_reg <= 1'b1;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == BK_MAC) && !issue_done_reg;
            v2_reg    <= v1_reg;

            if (coef_we)
                tvalid_reg[AW'(q_item.idx)] <= 1'b1;

            // step counter for the filter products
            if (state_reg == BK_MUL)
                step_reg <= step_reg + 3'd1;
            else
                step_reg <= '0;

            // history write and warm-up count
            if (hist_we)
            begin
                wp_reg    <= wp_inc;
                count_reg <= warm ? count_eff : count_eff + 1'b1;
                if (!warm)
                    held_reg <= '0;
            end

            // correlation issue side
            if (state_reg == BK_HIST)
                issue_done_reg <= 1'b0;
            else if ((state_reg == BK_MAC) && (j_reg == AW'(TAPS - 1)))
                issue_done_reg <= 1'b1;

            // saturated correlation or divide result
            if ((state_reg == BK_MAC) && !mac_busy && (acc_mag >= ACC_W'(MATCH_SAT)))
                held_reg <= (acc_reg < 0) ? 16'sh8000 : 16'sh7fff;
            if (state_reg == BK_FIX)
                held_reg <= neg_reg ? -signed'(fix_q) : signed'(fix_q);

            // result handoff
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                prior_in_reg  <= item_reg.value;
                prior_out_reg <= result;
                phase_reg     <= (phase_eff == PW'(DECIM - 1)) ? '0 : phase_eff + 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mul_reg <= prod;
        tv1_reg <= tvalid_reg[j_reg];

        if (q_pop)
            item_reg <= q_item;

        if (state_reg == BK_MUL)
        begin
            case (step_reg)
                3'd1: acc_reg <= ACC_W'(mul_reg);
                3'd2: lp_reg  <= sat16(div_trunc(40'(acc_reg) + 40'(mul_reg), 16));
                3'd3: ta_reg  <= sat16(div_trunc(40'(mul_reg), 17));
                3'd4:
                begin
                    hp_reg <= sat16(40'(ta_reg) + div_trunc(40'(mul_reg), 16));
                    if (item_reg.start)
                    begin
                        lp_reg <= item_reg.value;
                        hp_reg <= item_reg.value;
                    end
                end
                default: acc_reg <= acc_reg;
            endcase
        end

        // correlation setup, one tap per cycle
        if (state_reg == BK_HIST)
        begin
            acc_reg <= '0;
            j_reg   <= '0;
            rp_reg  <= wp_inc;
        end
        else if (state_reg == BK_MAC)
        begin
            if (!issue_done_reg)
            begin
                j_reg  <= j_reg + 1'b1;
                rp_reg <= rp_dec;
            end
            if (v2_reg)
                acc_reg <= acc_reg + ACC_W'(mul_reg);
            if (!mac_busy)
            begin
                neg_reg <= (acc_reg < 0);
                rem_reg <= acc_mag;
            end
        end

        // quotient estimate, corrected in the next cycle
        if (state_reg == BK_DIV)
            q_reg <= est_sum[QUOT_BITS+DIV_SH-1:DIV_SH];

        if (out_load)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // the correlation only runs once the history is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_MAC) |-> (count_reg == CW'(TAPS)))
        else $error("correlation started before history filled");

    // quotient estimate is never more than one short
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FIX) |-> (fix_rem < ACC_W'(2 * MATCH_DIV)))
        else $error("divide remainder out of range");

    // accumulator starts clean for every correlation
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_HIST) && warm |=> (acc_reg == '0))
        else $error("accumulator not cleared");

    // history write pointer stays inside the memory
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(wp_reg) < TAPS)
        else $error("history pointer out of range");

endmodule

/* hdl/selectable_audio_filter.sv */
// ----------------------------------------------------------------------------
// selectable_audio_filter
// Audio filter with pass, low-pass, high-pass and matched-filter modes.
// ----------------------------------------------------------------------------
// Input beats arrive on s_axis; tuser[0] selects a sample (0) or a template
// write (1), tuser[1] marks the first sample of a buffer and restarts every
// filter. Each sample beat yields one 16-bit beat on m_axis; template writes
// yield nothing. Registers are written on the cfg channel (cfg_ready is
// always high): 0 mode, 1 low-pass gain, 2 high-pass leak, gains in units
// of 1/65536. The user must write them only while the block is idle; the
// block itself does not enforce it.
// From the queue, a sample passes the filter product steps into the output
// register; the first sample of each decimation group of DECIM also writes
// the history and, once the history is full, runs the one-tap-per-cycle
// correlation on the shared multiplier, its pipeline drain and a divide by
// the match scale. A two-entry queue takes beats while the back end works,
// and the output register holds a result while m_axis stalls; the back end
// then waits and the queue fills, dropping s_axis_tready.
// Reset selects the matched filter with an all-zero template (per-tap valid
// bits, no clearing pass) and clears all filter history.
// ----------------------------------------------------------------------------
module selectable_audio_filter
    import saf_pkg::*;
#(
    parameter int TAPS  = 80,
    parameter int DECIM = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // sample_in[15:0], coef_index[22:16], coef_value[38:23]
    input  logic [1:0]  s_axis_tuser,  // kind[0], buffer_start[1]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // sample_out[15:0]
);

    cfg_t  cfg_reg;
    logic  q_valid, q_pop;
    item_t q_item;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= MODE_RST;
            cfg_reg.gain <= GAIN_RST;
            cfg_reg.leak <= LEAK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE: cfg_reg.mode <= cfg_data[1:0];
                CFG_GAIN: cfg_reg.gain <= cfg_data;
                CFG_LEAK: cfg_reg.leak <= cfg_data;
                default:  cfg_reg      <= cfg_reg;
            endcase
        end
    end

    saf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item)
    );

    saf_back #(.TAPS(TAPS), .DECIM(DECIM)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selectable audio filter: a directed table of
// register writes and beats, then random bursts of samples and template
// writes over several register settings, every output beat checked against
// a bit-exact predictor (own filter history, template copy) or a fixed value.
// ----------------------------------------------------------------------------
module tb
    import saf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS       = 80;
    localparam int NDECIM      = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 160;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 310;

    typedef enum logic { ROW_CFG, ROW_BEAT } row_kind_t;

    typedef struct {
        row_kind_t          rk;
        logic [1:0]         reg_idx;
        logic [16:0]        reg_val;
        logic               is_coef;
        logic signed [15:0] sample;
        logic               start;
        logic [6:0]         tap;
        logic signed [15:0] tap_val;
        logic               fixed;
        logic signed [15:0] fixed_out;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // sample_in[15:0], coef_index[22:16], coef_value[38:23]
    logic [1:0]  s_axis_tuser;   // kind[0], buffer_start[1]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // sample_out[15:0]

    // predictor copy of registers and filter state
    logic [1:0]         p_mode;
    logic [16:0]        p_gain;
    logic [16:0]        p_leak;
    logic signed [15:0] p_prev_in;
    logic signed [15:0] p_prev_out;
    int                 p_phase;
    int                 p_kept;
    logic signed [15:0] p_hist [NTAPS];
    logic signed [15:0] p_tmpl [NTAPS];
    logic signed [15:0] p_held;

    logic signed [15:0] pending_out [$];
    dir_row_t           dir_rows [$];
    int                 err_count;
    int                 burst_left;
    int                 idle_cycles;
    logic               long_hold_req;

    selectable_audio_filter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        err_count++;
    endtask

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // advance the predictor by one sample beat and return the output sample
    function automatic logic signed [15:0] filter_sample(input logic signed [15:0] xin,
                                                         input logic start);
        longint x, pin, pout, g, b, avg, lp, hp, ta, tb, acc;
        logic   warm;
        logic signed [15:0] res;
        x    = longint'(xin);
        pin  = longint'(p_prev_in);
        pout = longint'(p_prev_out);
        if (start) begin
            avg     = x;
            lp      = x;
            hp      = x;
            p_phase = 0;
            p_kept  = 0;
        end
        else begin
            g   = (p_gain > 17'd65536) ? 65536 : longint'(p_gain);
            b   = (p_leak > 17'd65536) ? 65536 : longint'(p_leak);
            avg = (x + pin) / 2;
            lp  = clip16((g * x + (65536 - g) * pout) / 65536);
            ta  = clip16(((131072 - b) * (x - pin)) / 131072);
            tb  = ((65536 - b) * pout) / 65536;
            hp  = clip16(ta + tb);
        end
        // decimated correlation on the first sample of each group
        if (p_phase == 0) begin
            warm = (p_kept >= NTAPS);
            for (int i = NTAPS - 1; i > 0; i--)
                p_hist[i] = p_hist[i - 1];
            p_hist[0] = avg[15:0];
            if (p_kept < NTAPS)
                p_kept++;
            if (warm) begin
                acc = 0;
                for (int i = 0; i < NTAPS; i++)
                    acc += longint'(p_hist[i]) * longint'(p_tmpl[i]);
                p_held = clip16(acc / MATCH_DIV);
            end
            else begin
                p_held = '0;
            end
        end
        p_phase++;
        if (p_phase >= NDECIM)
            p_phase = 0;
        case (p_mode)
            MODE_PASS: res = xin;
            MODE_LOW:  res = lp[15:0];
            MODE_HIGH: res = hp[15:0];
            default:   res = p_held;
        endcase
        p_prev_in  = xin;
        p_prev_out = res;
        return res;
    endfunction

    // wait for every output beat, then let a template write or a group finish
    task automatic drain_block();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        drain_block();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MODE: p_mode = val[1:0];
            CFG_GAIN: p_gain = val;
            CFG_LEAK: p_leak = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // send one input beat in sender bursts; returns after acceptance
    task automatic send_beat(input logic is_coef, input logic signed [15:0] sample,
                             input logic start, input logic [6:0] tap,
                             input logic signed [15:0] tap_val, input logic fixed,
                             input logic signed [15:0] fixed_out);
        logic signed [15:0] pred;
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  = {1'b0, tap_val, tap, sample};
        s_axis_tuser  = {start, is_coef};
        s_axis_tvalid = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        if (is_coef) begin
            if (tap < NTAPS)
                p_tmpl[tap] = tap_val;
        end
        else begin
            pred = filter_sample(sample, start);
            pending_out.push_back(fixed ? fixed_out : pred);
        end
    endtask

    task automatic random_beat();
        logic signed [15:0] v;
        logic [6:0] tap;
        case ($urandom_range(0, 7))
            0:       v = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
            1, 2:    v = 16'($urandom_range(0, 1023) - 512);
            default: v = 16'($urandom());
        endcase
        if ($urandom_range(0, 19) == 0) begin
            tap = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, NTAPS - 1));
            send_beat(1'b1, 16'($urandom()), ($urandom_range(0, 1) == 1), tap, v, 1'b0, '0);
        end
        else begin
            send_beat(1'b0, v, ($urandom_range(0, 499) == 0), 7'($urandom()),
                      16'($urandom()), 1'b0, '0);
        end
    endtask

    function automatic void dir_cfg(input logic [1:0] idx, input logic [16:0] val);
        dir_row_t r;
        r = '{ROW_CFG, idx, val, 1'b0, '0, 1'b0, '0, '0, 1'b0, '0};
        dir_rows.push_back(r);
    endfunction

    function automatic void dir_beat(input logic is_coef, input logic signed [15:0] sample,
                                     input logic start, input logic [6:0] tap,
                                     input logic signed [15:0] tap_val, input logic fixed,
                                     input logic signed [15:0] fixed_out);
        dir_row_t r;
        r = '{ROW_BEAT, CFG_MODE, '0, is_coef, sample, start, tap, tap_val, fixed,
              fixed_out};
        dir_rows.push_back(r);
    endfunction

    function automatic logic [16:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'h1ffff;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // output beat checking
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_out.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, '0);
            end
            else begin
                if (m_axis_tdata !== pending_out[0])
                    report_mismatch("sample_out", m_axis_tdata, pending_out[0]);
                void'(pending_out.pop_front());
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int pattern;
        logic held_once;
        held_once     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req && !held_once) begin
                held_once     = 1'b1;
                m_axis_tready = 1'b0;
                repeat (400) @(negedge clk);
            end
            pattern = int'($realtime / 2000.0);
            case (pattern % 4)
                0:       m_axis_tready = 1'b1;
                1:       m_axis_tready = ($urandom_range(0, 1) == 1);
                2:       m_axis_tready = ($urandom_range(0, 3) == 0);
                default: m_axis_tready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // stimulus
    initial begin
        dir_row_t r;
        err_count     = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_MODE;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        p_mode        = MODE_RST;
        p_gain        = GAIN_RST;
        p_leak        = LEAK_RST;
        p_prev_in     = '0;
        p_prev_out    = '0;
        p_phase       = 0;
        p_kept        = 0;
        p_held        = '0;
        for (int i = 0; i < NTAPS; i++)
        begin
            p_hist[i] = '0;
            p_tmpl[i] = '0;
        end

        // directed table: reset mode, template edges, every mode, gain extremes
        dir_beat(1'b1, '0, 1'b0, 7'd0, 16'sh7fff, 1'b0, '0);
        dir_beat(1'b1, '0, 1'b0, 7'd79, 16'sh8000, 1'b0, '0);
        dir_beat(1'b1, '0, 1'b0, 7'd127, 16'sd1, 1'b0, '0);
        dir_beat(1'b0, 16'sh8000, 1'b1, '0, '0, 1'b1, 16'sd0);
        dir_beat(1'b0, 16'sh7fff, 1'b0, '0, '0, 1'b1, 16'sd0);
        dir_cfg(CFG_MODE, 17'(MODE_PASS));
        dir_beat(1'b0, 16'sh7fff, 1'b1, '0, '0, 1'b1, 16'sh7fff);
        dir_beat(1'b0, 16'sh8000, 1'b0, '0, '0, 1'b1, 16'sh8000);
        dir_cfg(CFG_GAIN, 17'd65536);
        dir_cfg(CFG_MODE, 17'(MODE_LOW));
        dir_beat(1'b0, 16'sd1000, 1'b1, '0, '0, 1'b1, 16'sd1000);
        dir_beat(1'b0, 16'sh8000, 1'b0, '0, '0, 1'b0, '0);
        dir_beat(1'b0, 16'sh7fff, 1'b0, '0, '0, 1'b0, '0);
        dir_cfg(CFG_GAIN, 17'd0);
        dir_beat(1'b0, 16'sh7fff, 1'b0, '0, '0, 1'b0, '0);
        dir_cfg(CFG_GAIN, 17'h1ffff);
        dir_beat(1'b0, -16'sd5, 1'b0, '0, '0, 1'b0, '0);
        dir_cfg(CFG_MODE, 17'(MODE_HIGH));
        dir_cfg(CFG_LEAK, 17'd0);
        dir_beat(1'b0, 16'sh7fff, 1'b1, '0, '0, 1'b1, 16'sh7fff);
        dir_beat(1'b0, 16'sh8000, 1'b0, '0, '0, 1'b0, '0);
        dir_cfg(CFG_LEAK, 17'd65536);
        dir_beat(1'b0, 16'sh7fff, 1'b0, '0, '0, 1'b0, '0);
        dir_cfg(CFG_LEAK, 17'h1ffff);
        dir_beat(1'b0, 16'sh8000, 1'b0, '0, '0, 1'b0, '0);
        dir_beat(1'b0, 16'sd0, 1'b0, '0, '0, 1'b0, '0);

        // reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.rk == ROW_CFG)
                write_reg(r.reg_idx, r.reg_val);
            else
                send_beat(r.is_coef, r.sample, r.start, r.tap, r.tap_val, r.fixed,
                          r.fixed_out);
        end

        // load a full template, then restart a buffer for the matched filter
        write_reg(CFG_MODE, 17'(MODE_MATCH));
        for (int t = 0; t < NTAPS; t++)
            send_beat(1'b1, 16'($urandom()), 1'b0, t[6:0],
                      ($urandom_range(0, 1) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 255) - 128),
                      1'b0, '0);
        send_beat(1'b0, 16'($urandom()), 1'b1, '0, '0, 1'b0, '0);

        // random phases over several register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_GAIN, pick_gain());
            write_reg(CFG_LEAK, pick_gain());
            write_reg(CFG_MODE, 17'((ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3))));
            // long receiver hold-off while the sender keeps offering beats
            if (ph == 0)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_beat();
        end

        // finish
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
